[rtl/jls_pkg.sv]
// Shared types and character constants for the JSON line splitter.
// Used by the front end, the queue, the back end and the top level.
package jls_pkg;

  // Quoting state of the text scanner.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_NEWLN  = 3'd1,
    MODE_SQUOTE = 3'd2,
    MODE_DQUOTE = 3'd3,
    MODE_ESCAPE = 3'd4
  } mode_t;

  // Where an inserted newline goes relative to the text byte.
  typedef enum logic [1:0] {
    NL_NONE   = 2'd0,
    NL_BEFORE = 2'd1,
    NL_AFTER  = 2'd2
  } nl_kind_t;

  // One classified word waiting for the back end.
  typedef struct packed {
    logic [7:0] data;
    nl_kind_t   kind;
  } jls_entry_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_PRINT_LO = 8'h21;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

endpackage

[rtl/jls_front.sv]
// Front end of the JSON line splitter: tracks quoting and classifies each byte.
// Depends on jls_pkg; pushes classified words into jls_queue.
module jls_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               q_ready,
  output logic               q_push,
  output jls_pkg::jls_entry_t q_entry
);
  import jls_pkg::*;

  mode_t    mode;
  mode_t    mode_next;
  logic     keep;
  nl_kind_t kind;
  logic     accept;

  // A dropped byte is still accepted, so the front only waits on queue space.
  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  // Next quoting state for the byte on the input.
  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_SQUOTE: begin
        if (in_byte == CH_SQ) mode_next = MODE_NORMAL;
      end
      MODE_DQUOTE: begin
        if (in_byte == CH_DQ) mode_next = MODE_NORMAL;
        else if (in_byte == CH_BSL) mode_next = MODE_ESCAPE;
      end
      MODE_ESCAPE: mode_next = MODE_DQUOTE;
      default: begin
        // Unprintable bytes outside quotes leave the state untouched.
        if (in_byte >= CH_PRINT_LO && in_byte <= CH_PRINT_HI) begin
          priority if (in_byte == CH_DQ) mode_next = MODE_DQUOTE;
          else if (in_byte == CH_SQ) mode_next = MODE_SQUOTE;
          else if (in_byte == CH_LBRACE || in_byte == CH_LBRACK || in_byte == CH_COMMA)
            mode_next = MODE_NEWLN;
          else mode_next = MODE_NORMAL;
        end
      end
    endcase
  end

  // Whether the byte is kept and where a newline is inserted.
  always_comb begin
    keep = 1'b1;
    kind = NL_NONE;
    unique case (mode)
      MODE_SQUOTE, MODE_DQUOTE, MODE_ESCAPE: begin
        keep = 1'b1;
        kind = NL_NONE;
      end
      default: begin
        keep = (in_byte >= CH_PRINT_LO) && (in_byte <= CH_PRINT_HI);
        priority if ((in_byte == CH_RBRACE || in_byte == CH_RBRACK) && mode != MODE_NEWLN)
          kind = NL_BEFORE;
        else if (in_byte == CH_LBRACE || in_byte == CH_LBRACK || in_byte == CH_COMMA)
          kind = NL_AFTER;
        else kind = NL_NONE;
      end
    endcase
  end

  assign q_push        = accept && keep;
  assign q_entry.data  = in_byte;
  assign q_entry.kind  = kind;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

[rtl/jls_queue.sv]
// Small first-in first-out queue between the front and back ends.
// Depends on jls_pkg for the entry type.
module jls_queue #(
  parameter int DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  jls_pkg::jls_entry_t         push_entry,
  output logic                        push_ready,
  input  logic                        pop,
  output logic                        head_valid,
  output jls_pkg::jls_entry_t         head_entry,
  output logic [$clog2(DEPTH+1)-1:0]  count
);
  import jls_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  jls_entry_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

[rtl/jls_back.sv]
// Back end of the JSON line splitter: expands each queued word into one or
// two output bytes held in an output register. Depends on jls_pkg.
module jls_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  jls_pkg::jls_entry_t head_entry,
  output logic                pop,
  output logic                second,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                last
);
  import jls_pkg::*;

  logic       load;
  logic       second_next;
  logic [7:0] byte_next;
  logic       last_next;

  // A queued byte loads the output register when it is empty or being taken.
  assign load = head_valid && (!out_valid || out_ready);

  // Pick the piece of the head word to send this cycle.
  always_comb begin
    byte_next   = head_entry.data;
    last_next   = 1'b1;
    second_next = 1'b0;
    unique case (head_entry.kind)
      NL_BEFORE: begin
        byte_next   = second ? head_entry.data : CH_NL;
        last_next   = second;
        second_next = !second;
      end
      NL_AFTER: begin
        byte_next   = second ? CH_NL : head_entry.data;
        last_next   = second;
        second_next = !second;
      end
      default: begin
        byte_next   = head_entry.data;
        last_next   = 1'b1;
        second_next = 1'b0;
      end
    endcase
  end

  // The word leaves the queue with its final byte.
  assign pop = load && last_next;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second    <= second_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_next;
      last     <= last_next;
    end
  end

endmodule

[rtl/json_line_splitter_core.sv]
// Top level of the JSON line splitter: front end, queue and back end.
// Depends on jls_pkg, jls_front, jls_queue and jls_back.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------
//  input   | in_valid / in_ready   | in_byte[7:0]
//  output  | out_valid / out_ready | out_byte[7:0], last
//
// The front end accepts one byte per cycle while the queue has room; a byte
// that is dropped is accepted but produces nothing. The back end sends one
// output byte per cycle while a word is queued and the output is ready; a
// byte with an inserted newline yields two bytes. The output port sets the
// sustained rate. A result passes a queue slot, then the output register.
// Reset clears the quoting state, the queue and the output register.
// Either side may stall; the queue of DEPTH words absorbs the difference.
module json_line_splitter_core #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last
);
  import jls_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic          q_push;
  logic          q_ready;
  jls_entry_t    q_in;
  logic          q_pop;
  logic          q_valid;
  jls_entry_t    q_head;
  logic [CW-1:0] q_count;
  logic          second;

  jls_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  jls_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head),
    .count      (q_count)
  );

  jls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_entry (q_head),
    .pop        (q_pop),
    .second     (second),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last)
  );

  // The queue never holds more words than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(DEPTH))
    else $error("queue count above depth");

  // While the second byte of a word is pending, that word is still queued.
  a_second_has_head: assert property (@(posedge clk) disable iff (rst)
    second |-> q_valid)
    else $error("second byte pending without a queued word");

  // A byte that is not the last of its word leaves the second half pending.
  a_not_last_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> second)
    else $error("non-final byte shown without a pending second byte");

  // A word is popped only when it is present.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from an empty queue");

endmodule

[bench/json_line_splitter_core_tb.sv]
// Self-checking testbench for json_line_splitter_core, the JSON line splitter.
// Depends on jls_pkg and the RTL of the core; a built-in predictor tracks the
// quoting mode and checks every output word under random stalls on both sides.
module json_line_splitter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jls_pkg::*;

  // One predicted output word.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last;

  // Text waiting to be sent, and output words still owed by the block.
  logic [7:0] text_q[$];
  out_word_t  due_words[$];

  // Predictor state and run statistics.
  mode_t scan_mode = MODE_NORMAL;
  int    errors = 0;
  int    bytes_sent = 0;
  int    words_checked = 0;
  int    newlines_added = 0;
  int    in_gap = 0;
  int    out_stall = 0;
  bit    in_gaps_on = 1'b1;
  bit    out_stalls_on = 1'b1;

  json_line_splitter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Works out the words that one text byte produces and advances the mode.
  function automatic void split_byte(input logic [7:0] b);
    out_word_t words[$];
    case (scan_mode)
      MODE_SQUOTE: begin
        words.push_back('{data: b, last: 1'b0});
        if (b == CH_SQ) scan_mode = MODE_NORMAL;
      end
      MODE_DQUOTE: begin
        words.push_back('{data: b, last: 1'b0});
        if (b == CH_DQ) scan_mode = MODE_NORMAL;
        else if (b == CH_BSL) scan_mode = MODE_ESCAPE;
      end
      MODE_ESCAPE: begin
        words.push_back('{data: b, last: 1'b0});
        scan_mode = MODE_DQUOTE;
      end
      default: begin
        // Bytes outside the printable range vanish and leave the mode alone.
        if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
          if (scan_mode != MODE_NEWLN && (b == CH_RBRACE || b == CH_RBRACK)) begin
            words.push_back('{data: CH_NL, last: 1'b0});
          end
          words.push_back('{data: b, last: 1'b0});
          scan_mode = MODE_NORMAL;
          if (b == CH_DQ) begin
            scan_mode = MODE_DQUOTE;
          end else if (b == CH_SQ) begin
            scan_mode = MODE_SQUOTE;
          end else if (b == CH_LBRACE || b == CH_LBRACK || b == CH_COMMA) begin
            words.push_back('{data: CH_NL, last: 1'b0});
            scan_mode = MODE_NEWLN;
          end
          if (words.size() == 2) newlines_added++;
        end
      end
    endcase
    if (words.size() > 0) words[words.size() - 1].last = 1'b1;
    foreach (words[i]) due_words.push_back(words[i]);
  endfunction

  // Idle length: none when disabled; else mostly none, sometimes short, rarely a long pause.
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Driver: presents queued bytes with random gaps and predicts on acceptance.
  always @(posedge clk) begin : drive_p
    if (rst) begin
      in_valid <= 1'b0;
      in_byte  <= 8'h00;
    end else begin
      if (in_valid && in_ready) begin
        split_byte(in_byte);
        bytes_sent++;
        if ($urandom_range(0, 59) == 0) in_gaps_on = !in_gaps_on;
      end
      // A word still waiting for ready keeps valid and payload as they are.
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          in_valid <= 1'b1;
          in_byte  <= text_q.pop_front();
          in_gap = pick_gap(in_gaps_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted output word and stalls the output at random.
  always @(posedge clk) begin : watch_p
    out_word_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          errors++;
          $display("%0t: output word with nothing owed: expected none, got byte %h last %b",
                   $time, out_byte, last);
        end else begin
          w = due_words.pop_front();
          words_checked++;
          if (out_byte !== w.data) begin
            errors++;
            $display("%0t: out_byte mismatch: expected %h, got %h", $time, w.data, out_byte);
          end
          if (last !== w.last) begin
            errors++;
            $display("%0t: last mismatch: expected %b, got %b", $time, w.last, last);
          end
        end
        if ($urandom_range(0, 59) == 0) out_stalls_on = !out_stalls_on;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = pick_gap(out_stalls_on);
      end
    end
  end

  // Stimulus: directed corner cases, then random JSON-like text with noise.
  initial begin : stim_p
    string alnum;
    int counted;
    int r;
    int n;
    logic [7:0] c;
    alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-+.";
    counted = 0;

    // Edges of the printable range, control bytes and high bytes outside quotes.
    text_q.push_back(8'h20);
    text_q.push_back(CH_PRINT_LO);
    text_q.push_back(CH_PRINT_HI);
    text_q.push_back(8'h7F);
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h80);
    // A closing brace right after an inserted newline, with a dropped space between.
    add_text("{ }");
    // Closing bracket after text, then a comma followed by a closing brace.
    add_text("[a],}");
    // Double quotes with an escaped quote, a raw high byte, a raw newline and a brace inside.
    add_text("\"\\\"");
    text_q.push_back(8'hFF);
    text_q.push_back(CH_NL);
    add_text("}\"");
    // Single quotes: a double quote, a zero byte and a backslash pass unchanged.
    add_text("'\"");
    text_q.push_back(8'h00);
    add_text("\\'");

    // Random text built from JSON tokens, whitespace and noise.
    while (counted < 850) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        text_q.push_back(CH_LBRACE);
        counted++;
      end else if (r < 20) begin
        text_q.push_back(CH_LBRACK);
        counted++;
      end else if (r < 30) begin
        text_q.push_back($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK);
        counted++;
      end else if (r < 42) begin
        text_q.push_back(CH_COMMA);
        counted++;
      end else if (r < 47) begin
        add_text(":");
        counted++;
      end else if (r < 62) begin
        // Double-quoted string with escapes and arbitrary content bytes.
        text_q.push_back(CH_DQ);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(0, 99);
          if (r < 70) begin
            c = 8'($urandom_range(8'h21, 8'h7E));
            if (c == CH_DQ || c == CH_BSL) c = 8'h41;
            text_q.push_back(c);
          end else if (r < 85) begin
            text_q.push_back(CH_BSL);
            text_q.push_back(8'($urandom_range(0, 255)));
            counted++;
          end else begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_DQ || c == CH_BSL) c = 8'h00;
            text_q.push_back(c);
          end
          counted++;
        end
        text_q.push_back(CH_DQ);
        counted += 2;
      end else if (r < 68) begin
        // Single-quoted string; anything but the closing quote passes.
        text_q.push_back(CH_SQ);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_SQ) c = 8'hFF;
          text_q.push_back(c);
          counted++;
        end
        text_q.push_back(CH_SQ);
        counted += 2;
      end else if (r < 80) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) text_q.push_back(alnum[$urandom_range(0, alnum.len() - 1)]);
        counted += n;
      end else if (r < 93) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: text_q.push_back(8'h20);
            1: text_q.push_back(8'h09);
            2: text_q.push_back(CH_NL);
            default: text_q.push_back(8'h0D);
          endcase
        end
        counted += n;
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
        counted++;
      end
    end

    // Wait for every byte to be taken and every owed word to arrive.
    while (rst || text_q.size() != 0 || in_valid || due_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d text bytes; checked %0d output words, %0d with an inserted newline pair.",
             bytes_sent, words_checked, newlines_added);
    if (errors == 0 && due_words.size() == 0) begin
      $display("json_line_splitter_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d words still owed.", errors, due_words.size());
      $display("json_line_splitter_core regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d bytes unsent and %0d words owed.", text_q.size(), due_words.size());
    $display("json_line_splitter_core regression: fail");
    $finish;
  end

endmodule
